// ----- rtl/bus_window_address_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// bus_window_address_decoder_macros.svh
// Assertion macros used by the decoder top level.
// ----------------------------------------------------------------------------
`ifndef BUS_WINDOW_ADDRESS_DECODER_MACROS_SVH
`define BUS_WINDOW_ADDRESS_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is held low.
`define BWAD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bwad assertion failed");

// Next-cycle implication, disabled while reset is held low.
`define BWAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bwad assertion failed");

`endif

// ----- rtl/bwad_pkg.sv -----
// ----------------------------------------------------------------------------
// bwad_pkg
// Types, codes and defaults for the bus window address decoder.
// ----------------------------------------------------------------------------
package bwad_pkg;

    localparam int NUM_SLOTS_DEF      = 8;
    localparam int ADDR_BITS_DEF      = 32;
    localparam int DEVICE_ID_BITS_DEF = 8;

    localparam int OP_BITS     = 3;
    localparam int WIN_BITS    = 4;
    localparam int STATUS_BITS = 2;

    // APB-style config port: 64-bit data, registers on 8-byte strides
    localparam int PADDR_BITS = 4;
    localparam int PDATA_BITS = 64;
    localparam logic REG_BUS_SIZE = 1'b0;

    localparam longint unsigned BUS_SIZE_RESET = 64'd65536;

    typedef enum logic [OP_BITS-1:0] {
        OP_LOOKUP    = 3'd0,
        OP_CONNECT   = 3'd1,
        OP_DISC_DEV  = 3'd2,
        OP_DISC_BASE = 3'd3,
        OP_RESIZE    = 3'd4
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_WINDOW = 2'd1,
        ST_FULL       = 2'd2,
        ST_REMOVED    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_DRAIN,
        S_FINISH,
        S_R_RD,
        S_R_CHK,
        S_R_IN,
        S_R_DRAIN,
        S_R_WB
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch the accepted beat
        logic rd_en;     // read slot table at rd_idx
        logic ev_flat;   // evaluate read data for lookup / connect / disconnect
        logic ev_outer;  // resize: check candidate slot
        logic ev_inner;  // resize: check neighbour slot for collision
        logic wb;        // resize: write back or kill candidate
        logic finish;    // commit and load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_resize;
        logic need_inner;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/bwad_ctrl.sv -----
// ----------------------------------------------------------------------------
// bwad_ctrl
// Sequencer: walks the slot table once per beat, or slot by slot with a
// neighbour sweep for each resize candidate that needs one.
// ----------------------------------------------------------------------------
module bwad_ctrl #(
    parameter int NUM_SLOTS = bwad_pkg::NUM_SLOTS_DEF,
    localparam int IDX_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output bwad_pkg::t_cmd      o_cmd,
    output logic [IDX_BITS-1:0] o_rd_idx,
    input  bwad_pkg::t_sts      i_sts
);

    localparam logic [IDX_BITS-1:0] LAST = IDX_BITS'(NUM_SLOTS - 1);

    bwad_pkg::t_state    r_state, n_state;
    logic [IDX_BITS-1:0] r_idx, n_idx;
    logic [IDX_BITS-1:0] r_jdx, n_jdx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bwad_pkg::S_IDLE;
            r_idx   <= '0;
            r_jdx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_jdx   <= n_jdx;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_jdx    = r_jdx;
        o_cmd    = '0;
        o_rd_idx = r_idx;
        unique case (r_state)
            bwad_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = bwad_pkg::S_START;
                end
            end
            bwad_pkg::S_START: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.is_resize) begin
                    n_state = bwad_pkg::S_R_CHK;
                end else if (r_idx == LAST) begin
                    n_state = bwad_pkg::S_DRAIN;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = bwad_pkg::S_SCAN;
                end
            end
            bwad_pkg::S_SCAN: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.ev_flat = 1'b1;
                if (r_idx == LAST) begin
                    n_state = bwad_pkg::S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            bwad_pkg::S_DRAIN: begin
                o_cmd.ev_flat = 1'b1;
                n_state       = bwad_pkg::S_FINISH;
            end
            bwad_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = bwad_pkg::S_IDLE;
                end
            end
            bwad_pkg::S_R_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = bwad_pkg::S_R_CHK;
            end
            bwad_pkg::S_R_CHK: begin
                o_cmd.ev_outer = 1'b1;
                if (i_sts.need_inner) begin
                    n_jdx   = '0;
                    n_state = bwad_pkg::S_R_IN;
                end else if (r_idx == LAST) begin
                    n_state = bwad_pkg::S_FINISH;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = bwad_pkg::S_R_RD;
                end
            end
            bwad_pkg::S_R_IN: begin
                o_rd_idx       = r_jdx;
                o_cmd.rd_en    = 1'b1;
                o_cmd.ev_inner = 1'b1;
                if (r_jdx == LAST) begin
                    n_state = bwad_pkg::S_R_DRAIN;
                end else begin
                    n_jdx = r_jdx + 1'b1;
                end
            end
            bwad_pkg::S_R_DRAIN: begin
                o_cmd.ev_inner = 1'b1;
                n_state        = bwad_pkg::S_R_WB;
            end
            bwad_pkg::S_R_WB: begin
                o_cmd.wb = 1'b1;
                if (r_idx == LAST) begin
                    n_state = bwad_pkg::S_FINISH;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = bwad_pkg::S_R_RD;
                end
            end
            default: begin
                n_state = bwad_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != bwad_pkg::S_IDLE);

endmodule

// ----- rtl/bwad_dp.sv -----
// ----------------------------------------------------------------------------
// bwad_dp
// Slot table (one registered read port), beat registers, scan accumulators
// and result register.
// ----------------------------------------------------------------------------
module bwad_dp #(
    parameter int NUM_SLOTS      = bwad_pkg::NUM_SLOTS_DEF,
    parameter int ADDR_BITS      = bwad_pkg::ADDR_BITS_DEF,
    parameter int DEVICE_ID_BITS = bwad_pkg::DEVICE_ID_BITS_DEF,
    localparam int IDX_BITS      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    localparam int SB            = ADDR_BITS + 1,
    localparam int XB            = ADDR_BITS + 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bwad_pkg::t_cmd                   i_cmd,
    input  logic [IDX_BITS-1:0]              i_rd_idx,
    output bwad_pkg::t_sts                   o_sts,
    input  logic [SB-1:0]                    i_bus_size,
    input  logic [bwad_pkg::OP_BITS-1:0]     i_op,
    input  logic [ADDR_BITS-1:0]             i_address,
    input  logic [SB-1:0]                    i_window_size,
    input  logic [ADDR_BITS-1:0]             i_internal_base,
    input  logic [DEVICE_ID_BITS-1:0]        i_device_id,
    input  logic [bwad_pkg::WIN_BITS-1:0]    i_window_index,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_hit_device,
    output logic [DEVICE_ID_BITS-1:0]        o_target_id,
    output logic [ADDR_BITS-1:0]             o_local_address,
    output logic [bwad_pkg::STATUS_BITS-1:0] o_status
);

    // slot table; the offset field holds internal base minus bus base
    logic [ADDR_BITS-1:0]          r_mem_low  [NUM_SLOTS];
    logic [SB-1:0]                 r_mem_high [NUM_SLOTS];
    logic [ADDR_BITS-1:0]          r_mem_off  [NUM_SLOTS];
    logic [DEVICE_ID_BITS-1:0]     r_mem_own  [NUM_SLOTS];
    logic [bwad_pkg::WIN_BITS-1:0] r_mem_win  [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]          r_valid;

    // read port
    logic                          r_rvalid;
    logic [IDX_BITS-1:0]           r_ridx;
    logic [ADDR_BITS-1:0]          r_rd_low;
    logic [SB-1:0]                 r_rd_high;
    logic [ADDR_BITS-1:0]          r_rd_off;
    logic [DEVICE_ID_BITS-1:0]     r_rd_own;
    logic [bwad_pkg::WIN_BITS-1:0] r_rd_win;

    // beat
    logic [bwad_pkg::OP_BITS-1:0]  r_op;
    logic [ADDR_BITS-1:0]          r_addr;
    logic [SB-1:0]                 r_size;
    logic [ADDR_BITS-1:0]          r_int;
    logic [DEVICE_ID_BITS-1:0]     r_dev;
    logic [bwad_pkg::WIN_BITS-1:0] r_win;
    logic [XB-1:0]                 r_new_high;

    // accumulators
    logic                          r_hit;
    logic [DEVICE_ID_BITS-1:0]     r_hit_own;
    logic [ADDR_BITS-1:0]          r_hit_off;
    logic                          r_overlap;
    logic                          r_free_found;
    logic [IDX_BITS-1:0]           r_free_idx;
    logic [NUM_SLOTS-1:0]          r_kill;
    logic                          r_conflict;
    logic [IDX_BITS-1:0]           r_cur_idx;
    logic [ADDR_BITS-1:0]          r_cur_low;
    logic [SB-1:0]                 r_cur_nhigh;

    logic r_out_valid;

    logic w_is_lookup, w_is_connect, w_is_disc_dev, w_is_disc_base, w_is_resize;
    logic w_v, w_flat, w_in_win, w_overlap, w_match, w_rm_now, w_inner_hit;
    logic [XB-1:0] w_nhigh;
    logic w_conn_bad, w_conn_ok, w_commit;
    logic w_hwr_en;
    logic [IDX_BITS-1:0] w_hwr_idx;
    logic [SB-1:0] w_hwr_data;
    logic [bwad_pkg::STATUS_BITS-1:0] w_status;

    assign w_is_lookup    = (r_op == bwad_pkg::OP_LOOKUP);
    assign w_is_connect   = (r_op == bwad_pkg::OP_CONNECT);
    assign w_is_disc_dev  = (r_op == bwad_pkg::OP_DISC_DEV);
    assign w_is_disc_base = (r_op == bwad_pkg::OP_DISC_BASE);
    assign w_is_resize    = (r_op == bwad_pkg::OP_RESIZE);

    assign w_v    = r_valid[r_ridx];
    assign w_flat = i_cmd.ev_flat && r_rvalid;

    assign w_in_win  = w_v && (r_rd_low <= r_addr) && (SB'(r_addr) <= r_rd_high);
    assign w_overlap = w_v && (SB'(r_addr) <= r_rd_high) && (XB'(r_rd_low) <= r_new_high);

    // resize candidate
    assign w_nhigh  = XB'(r_rd_low) + XB'(r_size) - XB'(1);
    assign w_rm_now = (r_size == '0) || (w_nhigh >= XB'(i_bus_size));
    assign w_match  = w_v && (r_rd_own == r_dev) && (r_rd_win == r_win);
    assign w_inner_hit = w_v && (r_rd_low > r_cur_low) && (r_cur_nhigh >= SB'(r_rd_low));

    assign w_conn_bad = (r_size == '0) || (r_new_high >= XB'(i_bus_size)) || r_overlap;
    assign w_conn_ok  = w_is_connect && !w_conn_bad && r_free_found;
    assign w_commit   = i_cmd.finish && w_conn_ok;

    // single write port on the high field
    assign w_hwr_en   = w_commit || (i_cmd.wb && !r_conflict);
    assign w_hwr_idx  = w_commit ? r_free_idx : r_cur_idx;
    assign w_hwr_data = w_commit ? r_new_high[SB-1:0] : r_cur_nhigh;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_low  <= r_mem_low[i_rd_idx];
            r_rd_high <= r_mem_high[i_rd_idx];
            r_rd_off  <= r_mem_off[i_rd_idx];
            r_rd_own  <= r_mem_own[i_rd_idx];
            r_rd_win  <= r_mem_win[i_rd_idx];
            r_ridx    <= i_rd_idx;
        end
        if (w_commit) begin
            r_mem_low[r_free_idx] <= r_addr;
            r_mem_off[r_free_idx] <= r_int - r_addr;
            r_mem_own[r_free_idx] <= r_dev;
            r_mem_win[r_free_idx] <= r_win;
        end
        if (w_hwr_en) begin
            r_mem_high[w_hwr_idx] <= w_hwr_data;
        end
    end

    // beat registers and payload side of the accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_addr <= i_address;
            r_size <= i_window_size;
            r_int  <= i_internal_base;
            r_dev  <= i_device_id;
            r_win  <= i_window_index;
        end
        r_new_high <= XB'(r_addr) + XB'(r_size) - XB'(1);
        if (w_flat && w_is_lookup && w_in_win && !r_hit) begin
            r_hit_own <= r_rd_own;
            r_hit_off <= r_rd_off;
        end
        if (w_flat && w_is_connect && !w_v && !r_free_found) begin
            r_free_idx <= r_ridx;
        end
        if (i_cmd.ev_outer) begin
            r_cur_idx   <= r_ridx;
            r_cur_low   <= r_rd_low;
            r_cur_nhigh <= w_nhigh[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_kill       <= '0;
            r_rvalid     <= 1'b0;
            r_hit        <= 1'b0;
            r_overlap    <= 1'b0;
            r_free_found <= 1'b0;
            r_conflict   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_rvalid <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_kill       <= '0;
                r_hit        <= 1'b0;
                r_overlap    <= 1'b0;
                r_free_found <= 1'b0;
            end
            if (w_flat) begin
                if (w_is_lookup && w_in_win) r_hit <= 1'b1;
                if (w_is_connect && w_overlap) r_overlap <= 1'b1;
                if (w_is_connect && !w_v) r_free_found <= 1'b1;
                if (w_is_disc_dev && w_v && (r_rd_own == r_dev)) begin
                    r_valid[r_ridx] <= 1'b0;
                end
                if (w_is_disc_base && w_v && (r_rd_low == r_addr)) begin
                    r_valid[r_ridx] <= 1'b0;
                end
            end
            if (i_cmd.ev_outer) begin
                r_conflict <= 1'b0;
                if (w_match && w_rm_now) r_kill[r_ridx] <= 1'b1;
            end
            if (i_cmd.ev_inner && r_rvalid && w_inner_hit) r_conflict <= 1'b1;
            if (i_cmd.wb && r_conflict) r_kill[r_cur_idx] <= 1'b1;
            if (w_commit) r_valid[r_free_idx] <= 1'b1;
            if (i_cmd.finish && w_is_resize) r_valid <= r_valid & ~r_kill;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        w_status = bwad_pkg::ST_OK;
        priority if (w_is_connect && w_conn_bad) begin
            w_status = bwad_pkg::ST_BAD_WINDOW;
        end else if (w_is_connect && !r_free_found) begin
            w_status = bwad_pkg::ST_FULL;
        end else if (w_is_resize && (r_kill != '0)) begin
            w_status = bwad_pkg::ST_REMOVED;
        end else begin
            w_status = bwad_pkg::ST_OK;
        end
    end

    // result register (payload)
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_hit_device <= w_is_lookup && r_hit;
            o_target_id  <= (w_is_lookup && r_hit) ? r_hit_own : '0;
            if (w_is_lookup) begin
                o_local_address <= r_hit ? (r_addr + r_hit_off) : r_addr;
            end else begin
                o_local_address <= '0;
            end
            o_status <= w_status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_sts.is_resize  = w_is_resize;
    assign o_sts.need_inner = w_match && !w_rm_now;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

endmodule

// ----- rtl/bus_window_address_decoder.sv -----
// ----------------------------------------------------------------------------
// bus_window_address_decoder
// Window table decoder: connect, disconnect, resize and look up bus windows.
// ----------------------------------------------------------------------------
// Usage:
//  - Command beats enter on i_in_valid / o_in_stall; one result beat leaves
//    on o_out_valid / i_out_stall for every command beat, in order.
//  - One beat is worked on at a time. The slot table has one registered
//    read port, read once a cycle. Lookup, connect and both disconnects
//    sweep all NUM_SLOTS slots in order, then finish. Resize reads and
//    checks each slot in turn and, for every slot of the device/index that
//    survives the size checks, sweeps the table again for the window above
//    it before writing back or killing that slot.
//  - The result register frees the input side: a new beat is taken while a
//    result still waits. A stalled result holds the block in its final step
//    until the receiver takes it.
//  - Reset (synchronous, active low) empties the table and sets bus_size to
//    65536. Entry fields are never cleared; only valid slots are looked at.
//  - bus_size is written over the APB-style port at byte address 0, 64-bit
//    data. The user must write it only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "bus_window_address_decoder_macros.svh"

module bus_window_address_decoder #(
    parameter int NUM_SLOTS      = bwad_pkg::NUM_SLOTS_DEF,
    parameter int ADDR_BITS      = bwad_pkg::ADDR_BITS_DEF,
    parameter int DEVICE_ID_BITS = bwad_pkg::DEVICE_ID_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command beat
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [bwad_pkg::OP_BITS-1:0]     i_op,
    input  logic [ADDR_BITS-1:0]             i_address,
    input  logic [ADDR_BITS:0]               i_window_size,
    input  logic [ADDR_BITS-1:0]             i_internal_base,
    input  logic [DEVICE_ID_BITS-1:0]        i_device_id,
    input  logic [bwad_pkg::WIN_BITS-1:0]    i_window_index,
    // result beat
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_hit_device,
    output logic [DEVICE_ID_BITS-1:0]        o_target_id,
    output logic [ADDR_BITS-1:0]             o_local_address,
    output logic [bwad_pkg::STATUS_BITS-1:0] o_status,
    // config port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bwad_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [bwad_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [bwad_pkg::PDATA_BITS-1:0]  prdata,
    output logic                             pready
);

    localparam int IDX_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SB       = ADDR_BITS + 1;

    logic [SB-1:0]       r_bus_size;
    logic                w_reg_sel;
    logic                w_cfg_wr;
    bwad_pkg::t_cmd      w_cmd;
    bwad_pkg::t_sts      w_sts;
    logic [IDX_BITS-1:0] w_rd_idx;

    // register select ignores the byte offset within the 8-byte slot
    assign w_reg_sel = (paddr[bwad_pkg::PADDR_BITS-1:3] == bwad_pkg::REG_BUS_SIZE);
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = w_reg_sel ? bwad_pkg::PDATA_BITS'(r_bus_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_size <= SB'(bwad_pkg::BUS_SIZE_RESET);
        end else if (w_cfg_wr && w_reg_sel) begin
            r_bus_size <= pwdata[SB-1:0];
        end
    end

    bwad_ctrl #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .o_rd_idx   (w_rd_idx),
        .i_sts      (w_sts)
    );

    bwad_dp #(
        .NUM_SLOTS      (NUM_SLOTS),
        .ADDR_BITS      (ADDR_BITS),
        .DEVICE_ID_BITS (DEVICE_ID_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_rd_idx        (w_rd_idx),
        .o_sts           (w_sts),
        .i_bus_size      (r_bus_size),
        .i_op            (i_op),
        .i_address       (i_address),
        .i_window_size   (i_window_size),
        .i_internal_base (i_internal_base),
        .i_device_id     (i_device_id),
        .i_window_index  (i_window_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hit_device    (o_hit_device),
        .o_target_id     (o_target_id),
        .o_local_address (o_local_address),
        .o_status        (o_status)
    );

    // an accepted beat closes the input side in the following cycle
    `BWAD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // a result is only loaded into a free output register
    `BWAD_ASSERT_IMPL(a_finish_free, i_clk, i_rst_n, w_cmd.finish, !o_out_valid || !i_out_stall)
    // a loaded result is presented in the next cycle
    `BWAD_ASSERT_NEXT(a_finish_shows, i_clk, i_rst_n, w_cmd.finish, o_out_valid)
    // no table traffic while waiting for a beat
    `BWAD_ASSERT_IMPL(a_idle_quiet, i_clk, i_rst_n, !o_in_stall, !w_cmd.rd_en && !w_cmd.wb && !w_cmd.finish)

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bus window address decoder. Command beats are
// sent in random bursts while the result side stalls on its own pattern. A
// model of the window table in the bench predicts every result beat, and
// each beat is compared field by field in order. The bus size register is
// written and read back over the config port between phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NS  = bwad_pkg::NUM_SLOTS_DEF;
    localparam int AW  = bwad_pkg::ADDR_BITS_DEF;
    localparam int DW  = bwad_pkg::DEVICE_ID_BITS_DEF;
    localparam int OPB = bwad_pkg::OP_BITS;
    localparam int WB  = bwad_pkg::WIN_BITS;
    localparam int PAB = bwad_pkg::PADDR_BITS;
    localparam int PDB = bwad_pkg::PDATA_BITS;

    localparam int      CLK_HALF_NS  = 10;
    localparam int      RESET_CYCLES = 6;
    localparam int      TAIL_CYCLES  = 40;
    localparam int      REPORT_MAX   = 10;
    // watchdog time limit for the whole run
    localparam longint  LIMIT_NS     = 64'd20_000_000;

    // op codes past resize do nothing and must give an all-zero result
    localparam bit [OPB-1:0] OP_SPARE_FIRST = OPB'(int'(bwad_pkg::OP_RESIZE) + 1);
    localparam bit [OPB-1:0] OP_SPARE_LAST  = '1;

    typedef bit [AW-1:0] t_addr;
    typedef bit [AW:0]   t_size;
    typedef bit [DW-1:0] t_dev;
    typedef bit [WB-1:0] t_win;

    typedef struct {
        bit [OPB-1:0] op;
        t_addr        addr;
        t_size        size;
        t_addr        ibase;
        t_dev         dev;
        t_win         win;
    } t_item;

    typedef struct {
        bit [OPB-1:0]      op;
        bit                hit;
        t_dev              target;
        t_addr             local_addr;
        bwad_pkg::t_status status;
    } t_reply;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_in_valid;
    logic                             o_in_stall;
    logic [OPB-1:0]                   i_op;
    logic [AW-1:0]                    i_address;
    logic [AW:0]                      i_window_size;
    logic [AW-1:0]                    i_internal_base;
    logic [DW-1:0]                    i_device_id;
    logic [WB-1:0]                    i_window_index;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic                             o_hit_device;
    logic [DW-1:0]                    o_target_id;
    logic [AW-1:0]                    o_local_address;
    logic [bwad_pkg::STATUS_BITS-1:0] o_status;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [PAB-1:0]                   paddr;
    logic [PDB-1:0]                   pwdata;
    logic [PDB-1:0]                   prdata;
    logic                             pready;

    bus_window_address_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_address       (i_address),
        .i_window_size   (i_window_size),
        .i_internal_base (i_internal_base),
        .i_device_id     (i_device_id),
        .i_window_index  (i_window_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hit_device    (o_hit_device),
        .o_target_id     (o_target_id),
        .o_local_address (o_local_address),
        .o_status        (o_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Window table model: bench copy of the slots and the bus size
    // ------------------------------------------------------------------------
    t_size bus_limit = t_size'(bwad_pkg::BUS_SIZE_RESET);
    bit    win_used [NS];
    t_addr win_lo   [NS];
    t_addr win_hi   [NS];
    t_addr win_int  [NS];
    t_dev  win_dev  [NS];
    t_win  win_idx  [NS];

    t_reply pending_replies[$];
    int     fail_count  = 0;
    int     burst_left  = 0;

    function automatic void note_mismatch(string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t ns: %s", $time, msg);
    endfunction

    function automatic longint unsigned rand_below(longint unsigned n);
        return {$urandom, $urandom} % n;
    endfunction

    // Overlap is checked across the whole table before fullness, so an
    // overlapping window on a full table reports a bad window.
    function automatic bwad_pkg::t_status connect_window(t_item c);
        longint unsigned top;
        int              slot;
        bit              clash;
        slot  = -1;
        clash = 1'b0;
        if (c.size == 0)
            return bwad_pkg::ST_BAD_WINDOW;
        top = 64'(c.addr) + 64'(c.size) - 1;
        if (top >= 64'(bus_limit))
            return bwad_pkg::ST_BAD_WINDOW;
        for (int i = 0; i < NS; i++) begin
            if (!win_used[i]) begin
                if (slot < 0)
                    slot = i;
            end else if (c.addr <= win_hi[i] && 64'(win_lo[i]) <= top) begin
                clash = 1'b1;
            end
        end
        if (clash)
            return bwad_pkg::ST_BAD_WINDOW;
        if (slot < 0)
            return bwad_pkg::ST_FULL;
        win_used[slot] = 1'b1;
        win_lo[slot]   = c.addr;
        win_hi[slot]   = t_addr'(top);
        win_int[slot]  = c.ibase;
        win_dev[slot]  = c.dev;
        win_idx[slot]  = c.win;
        return bwad_pkg::ST_OK;
    endfunction

    // All matching windows are judged against the table as it stood before
    // the resize; touching the low end of the next window up kills a window.
    function automatic bwad_pkg::t_status resize_windows(t_item c);
        bit                keep  [NS];
        longint unsigned   grown [NS];
        bwad_pkg::t_status st;
        st = bwad_pkg::ST_OK;
        for (int i = 0; i < NS; i++) begin
            keep[i]  = 1'b1;
            grown[i] = 64'(win_hi[i]);
            if (win_used[i] && win_dev[i] == c.dev && win_idx[i] == c.win) begin
                if (c.size == 0) begin
                    keep[i] = 1'b0;
                end else begin
                    grown[i] = 64'(win_lo[i]) + 64'(c.size) - 1;
                    if (grown[i] >= 64'(bus_limit))
                        keep[i] = 1'b0;
                    for (int j = 0; j < NS; j++)
                        if (j != i && win_used[j] && win_lo[j] > win_lo[i]
                            && grown[i] >= 64'(win_lo[j]))
                            keep[i] = 1'b0;
                end
            end
        end
        for (int i = 0; i < NS; i++) begin
            if (win_used[i]) begin
                if (!keep[i]) begin
                    win_used[i] = 1'b0;
                    st = bwad_pkg::ST_REMOVED;
                end else begin
                    win_hi[i] = t_addr'(grown[i]);
                end
            end
        end
        return st;
    endfunction

    // Works out the result of one accepted command beat and updates the table.
    function automatic t_reply decode_predict(t_item c);
        t_reply r;
        r.op         = c.op;
        r.hit        = 1'b0;
        r.target     = '0;
        r.local_addr = '0;
        r.status     = bwad_pkg::ST_OK;
        case (c.op)
            bwad_pkg::OP_LOOKUP: begin
                r.local_addr = c.addr;
                for (int i = 0; i < NS; i++) begin
                    if (!r.hit && win_used[i] && win_lo[i] <= c.addr
                        && c.addr <= win_hi[i]) begin
                        r.hit        = 1'b1;
                        r.target     = win_dev[i];
                        r.local_addr = c.addr - win_lo[i] + win_int[i];
                    end
                end
            end
            bwad_pkg::OP_CONNECT:   r.status = connect_window(c);
            bwad_pkg::OP_DISC_DEV: begin
                for (int i = 0; i < NS; i++)
                    if (win_used[i] && win_dev[i] == c.dev)
                        win_used[i] = 1'b0;
            end
            bwad_pkg::OP_DISC_BASE: begin
                for (int i = 0; i < NS; i++)
                    if (win_used[i] && win_lo[i] == c.addr)
                        win_used[i] = 1'b0;
            end
            bwad_pkg::OP_RESIZE:    r.status = resize_windows(c);
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_item mk(bit [OPB-1:0] op, t_addr addr, t_size size,
                                 t_addr ibase, t_dev dev, t_win win);
        t_item c;
        c.op    = op;
        c.addr  = addr;
        c.size  = size;
        c.ibase = ibase;
        c.dev   = dev;
        c.win   = win;
        return c;
    endfunction

    function automatic int any_window();
        int picks[$];
        for (int i = 0; i < NS; i++)
            if (win_used[i])
                picks.push_back(i);
        if (picks.size() == 0)
            return -1;
        return picks[$urandom_range(0, picks.size() - 1)];
    endfunction

    // Mostly well-formed traffic aimed at the live windows: hits, edges,
    // adjacent bases, resizes that just reach the next window or the bus end.
    // A slice is full-width noise so that every input bit toggles.
    function automatic t_item random_cmd();
        t_item           c;
        int              s;
        int              roll;
        bit              found;
        longint unsigned span;
        longint unsigned above;
        found = 1'b0;
        above = 0;
        span  = 64'(bus_limit) >> 5;
        if (span == 0)
            span = 1;
        s       = any_window();
        c.op    = bwad_pkg::OP_LOOKUP;
        c.addr  = $urandom;
        c.size  = t_size'(1 + rand_below(span));
        c.ibase = $urandom;
        c.dev   = ($urandom_range(0, 4) == 0) ? t_dev'($urandom) : t_dev'($urandom_range(0, 5));
        c.win   = ($urandom_range(0, 4) == 0) ? t_win'($urandom) : t_win'($urandom_range(0, 2));
        roll    = $urandom_range(0, 99);
        if (roll < 30) begin
            if (s >= 0 && $urandom_range(0, 3) != 0)
                c.addr = win_lo[s] + t_addr'(rand_below(64'(win_hi[s]) - 64'(win_lo[s]) + 1));
            else if ($urandom_range(0, 1) != 0)
                c.addr = t_addr'(rand_below(64'(bus_limit)));
        end else if (roll < 60) begin
            c.op   = bwad_pkg::OP_CONNECT;
            c.addr = t_addr'(rand_below(64'(bus_limit)));
            case ($urandom_range(0, 9))
                0: c.size = '0;
                1: c.size = t_size'({$urandom, $urandom});
                2: if (s >= 0) c.addr = win_hi[s] + 1;
                3: if (s >= 0) c.addr = win_hi[s];
                4: c.addr = $urandom;
                default: ;
            endcase
        end else if (roll < 70) begin
            c.op = bwad_pkg::OP_DISC_DEV;
            if (s >= 0 && $urandom_range(0, 3) != 0)
                c.dev = win_dev[s];
        end else if (roll < 80) begin
            c.op   = bwad_pkg::OP_DISC_BASE;
            c.addr = (s >= 0 && $urandom_range(0, 3) != 0) ? win_lo[s]
                                                            : t_addr'(rand_below(64'(bus_limit)));
        end else if (roll < 97) begin
            c.op = bwad_pkg::OP_RESIZE;
            if (s >= 0 && $urandom_range(0, 4) != 0) begin
                c.dev = win_dev[s];
                c.win = win_idx[s];
            end
            case ($urandom_range(0, 7))
                0: c.size = '0;
                1: c.size = t_size'({$urandom, $urandom});
                2, 3: if (s >= 0) begin
                    for (int k = 0; k < NS; k++)
                        if (win_used[k] && win_lo[k] > win_lo[s]
                            && (!found || 64'(win_lo[k]) < above)) begin
                            found = 1'b1;
                            above = 64'(win_lo[k]);
                        end
                    if (found)
                        c.size = t_size'(above - 64'(win_lo[s]) + $urandom_range(0, 1));
                end
                4: if (s >= 0)
                    c.size = t_size'(64'(bus_limit) - 64'(win_lo[s]) + $urandom_range(0, 1));
                default: ;
            endcase
        end else begin
            c.op = OP_SPARE_FIRST + OPB'($urandom_range(0, 2));
        end
        return c;
    endfunction

    // Present one command beat, hold it until taken, then maybe idle.
    // Valid stays high between beats of a burst.
    task automatic send_cmd(t_item c);
        int gap;
        @(negedge i_clk);
        i_op            = c.op;
        i_address       = c.addr;
        i_window_size   = c.size;
        i_internal_base = c.ibase;
        i_device_id     = c.dev;
        i_window_index  = c.win;
        i_in_valid      = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_replies.push_back(decode_predict(c));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // long gap-free runs now and then, short bursts otherwise
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(0, 6);
            gap = $urandom_range(1, 14);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_replies();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // One APB transfer to the bus size register; a read checks prdata.
    task automatic apb_access(bit wr, bit [PDB-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = PAB'(bwad_pkg::REG_BUS_SIZE) << 3;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (!wr && prdata !== PDB'(bus_limit))
            note_mismatch($sformatf("bus_size read: expected %h, got %h",
                                    PDB'(bus_limit), prdata));
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Register writes only with the block idle: drain, settle, write, read back.
    task automatic set_bus_size(longint unsigned value);
        drain_replies();
        repeat (4) @(negedge i_clk);
        apb_access(1'b1, PDB'(value));
        bus_limit = t_size'(value);
        apb_access(1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Result side: own stall pattern, and in-order checking of each beat
    // ------------------------------------------------------------------------
    int rx_left = 0;
    bit rx_hold = 1'b0;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    rx_hold = 1'b0;
                    rx_left = $urandom_range(20, 60);
                end
                1: begin
                    rx_hold = 1'b1;
                    rx_left = $urandom_range(1, 12);
                end
                default: begin
                    rx_hold = $urandom_range(0, 1);
                    rx_left = $urandom_range(1, 4);
                end
            endcase
        end else begin
            rx_left--;
        end
        i_out_stall = rx_hold;
    end

    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_replies.size() == 0) begin
                note_mismatch("result beat with no command pending");
            end else begin
                want = pending_replies.pop_front();
                if (o_hit_device !== want.hit || o_target_id !== want.target
                    || o_local_address !== want.local_addr || o_status !== want.status)
                    note_mismatch($sformatf(
                        "op %0d: expected hit %0b id %h addr %h st %0d, got hit %b id %h addr %h st %0d",
                        want.op, want.hit, want.target, want.local_addr, want.status,
                        o_hit_device, o_target_id, o_local_address, o_status));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // reset value, both extremes, then back to the reset value
    task automatic test_register_access();
        apb_access(1'b0, '0);
        set_bus_size(1);
        set_bus_size(64'h1_0000_0000);
        set_bus_size(bwad_pkg::BUS_SIZE_RESET);
    endtask

    // Hand-picked beats at the default 64K bus: every op and every corner.
    task automatic test_directed_ops();
        // miss on an empty table keeps the address
        send_cmd(mk(bwad_pkg::OP_LOOKUP, '1, '0, '0, '0, '0));
        // zero size, then past the bus with the largest size
        send_cmd(mk(bwad_pkg::OP_CONNECT, 32'h0000_2000, '0, '0, 8'h01, '0));
        send_cmd(mk(bwad_pkg::OP_CONNECT, 32'h0000_FFF0, '1, '1, '1, '1));
        // translation wraps modulo 2^32
        send_cmd(mk(bwad_pkg::OP_CONNECT, 32'h0000_1000, 33'h100, 32'hFFFF_FF80, '1, '1));
        send_cmd(mk(bwad_pkg::OP_LOOKUP, 32'h0000_10FF, '0, '0, '0, '0));
        send_cmd(mk(bwad_pkg::OP_CONNECT, 32'h0000_10FF, 33'h1, '0, 8'h07, '0));
        // same device and index twice, ranges apart
        send_cmd(mk(bwad_pkg::OP_CONNECT, 32'h0000_2000, 33'h100, 32'h10, 8'h01, '0));
        send_cmd(mk(bwad_pkg::OP_CONNECT, 32'h0000_3000, 33'h100, 32'h20, 8'h01, '0));
        // grow to one below the next window, then onto its base
        send_cmd(mk(bwad_pkg::OP_RESIZE, '0, 33'h1000, '0, 8'h01, '0));
        send_cmd(mk(bwad_pkg::OP_RESIZE, '0, 33'h1001, '0, 8'h01, '0));
        // resize with nothing matching, resize to zero
        send_cmd(mk(bwad_pkg::OP_RESIZE, '0, 33'h10, '0, 8'h09, '0));
        send_cmd(mk(bwad_pkg::OP_RESIZE, '0, '0, '0, '1, '1));
        // resize running past the bus
        send_cmd(mk(bwad_pkg::OP_CONNECT, 32'h0000_F000, 33'h10, '0, 8'h02, 4'h1));
        send_cmd(mk(bwad_pkg::OP_RESIZE, '0, 33'h1001, '0, 8'h02, 4'h1));
        // disconnect device with no match
        send_cmd(mk(bwad_pkg::OP_DISC_DEV, '0, '0, '0, 8'h55, '0));
        // fill the table, then full and overlap-on-full
        for (int i = 0; i < NS - 1; i++)
            send_cmd(mk(bwad_pkg::OP_CONNECT, 32'h0000_8000 + 32'(i) * 32'h100, 33'h80,
                        32'(i) << 12, 8'h03, t_win'(i)));
        send_cmd(mk(bwad_pkg::OP_CONNECT, 32'h0000_C000, 33'h10, '0, 8'h04, '0));
        send_cmd(mk(bwad_pkg::OP_CONNECT, 32'h0000_8000, 33'h1, '0, 8'h04, '0));
        // spare op code with every field at its top
        send_cmd(mk(OP_SPARE_LAST, '1, '1, '1, '1, '1));
        send_cmd(mk(bwad_pkg::OP_DISC_BASE, 32'h0000_3000, '0, '0, '0, '0));
        send_cmd(mk(bwad_pkg::OP_DISC_DEV, '0, '0, '0, 8'h03, '0));
        send_cmd(mk(bwad_pkg::OP_LOOKUP, 32'h0000_8005, '0, '0, '0, '0));
    endtask

    // Random traffic at one bus size; halfway it lets every result come home.
    task automatic test_random_windows(longint unsigned size_val, int count);
        set_bus_size(size_val);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2)
                drain_replies();
            send_cmd(random_cmd());
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_op            = '0;
        i_address       = '0;
        i_window_size   = '0;
        i_internal_base = '0;
        i_device_id     = '0;
        i_window_index  = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_access();
        test_directed_ops();
        test_random_windows(bwad_pkg::BUS_SIZE_RESET, 500);
        test_random_windows(1, 200);
        test_random_windows(64'h1_0000_0000, 500);
        test_random_windows(64'h0_C000_0001, 500);

        drain_replies();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_replies.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog: a hang anywhere ends the run as a failure
    initial begin
        #(LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/bwad_pkg.sv
rtl/bwad_ctrl.sv
rtl/bwad_dp.sv
rtl/bus_window_address_decoder.sv
tb/tb_top.sv
